// File: hdl/cvpz_pkg.sv
// Shared types and constants for the complex viewport pan and zoom core.
package cvpz_pkg;

  // Field widths.
  localparam int LOW_W  = 32;
  localparam int SPAN_W = 31;
  localparam int CUR_W  = 10;
  localparam int DIR_W  = 2;

  // Divider dividend width: cursor times span.
  localparam int DVD_W  = CUR_W + SPAN_W;

  // Operand width of the shared multiplier and width of the full reciprocal product.
  localparam int HALF_W = (DVD_W + 1) / 2;
  localparam int ACC_W  = 2 * DVD_W;

  // Signed width for the low-edge update (low plus a quotient plus a span).
  localparam int WIDE_W = 44;

  // Q3.28 constants.
  localparam logic [LOW_W-1:0]  LOW_RST  = 32'hE000_0000;
  localparam logic [SPAN_W-1:0] SPAN_RST = 31'h4000_0000;
  localparam logic [SPAN_W-1:0] SPAN_MAX = 31'h4000_0000;

  localparam logic signed [WIDE_W-1:0] NEG_TWO_W = -44'sd536870912;
  localparam logic signed [WIDE_W-1:0] POS_TWO_W = 44'sd536870912;
  localparam logic signed [WIDE_W-1:0] LOW_MAX_W = 44'sd2147483647;
  localparam logic signed [WIDE_W-1:0] LOW_MIN_W = -44'sd2147483648;

  // Divisors used by the commands.
  localparam int PAN_DIVISOR = 10;
  localparam int ZIN_SCALE   = 4;
  localparam int ZOUT_SCALE  = 3;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_UP = 2'b01;

  typedef enum logic [1:0] {
    MODE_PAN  = 2'd0,
    MODE_ZIN  = 2'd1,
    MODE_ZOUT = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_STL  = 7'b0000100,
    S_WTL  = 7'b0001000,
    S_STS  = 7'b0010000,
    S_WTS  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // Steps of the shared divider.
  typedef enum logic [6:0] {
    D_IDLE = 7'b0000001,
    D_MUL0 = 7'b0000010,
    D_MUL1 = 7'b0000100,
    D_MUL2 = 7'b0001000,
    D_MUL3 = 7'b0010000,
    D_FIX  = 7'b0100000,
    D_INC  = 7'b1000000
  } div_step_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// File: hdl/cvpz_div.sv
// Shared divider by a constant: reciprocal product on one multiplier, then one correction.
module cvpz_div
  import cvpz_pkg::*;
#(
  parameter int DVS_W = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  // Reciprocal of the divisor: floor(2^DVD_W / divisor).
  input  logic [DVD_W-1:0] recip,
  output div_rsp_t         rsp,
  output logic [DVD_W-1:0] quotient
);

  // The estimate (dividend * recip) >> DVD_W is at most one below the true
  // quotient, so a single remainder check finishes the division. The remainder
  // is below twice the divisor, so its low DVS_W+1 bits are exact.

  div_step_t           step_r, step_nxt;
  logic                done_r, done_nxt;
  logic [DVD_W-1:0]    n_r, n_nxt;
  logic [DVD_W-1:0]    m_r, m_nxt;
  logic [DVS_W-1:0]    d_r, d_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [DVS_W:0]      rem_r, rem_nxt;
  logic [DVD_W-1:0]    quo_r, quo_nxt;
  logic [HALF_W-1:0]   n_lo, n_hi, m_lo, m_hi;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [2*HALF_W-1:0] prod;

  assign n_lo = n_r[HALF_W-1:0];
  assign n_hi = HALF_W'(n_r[DVD_W-1:HALF_W]);
  assign m_lo = m_r[HALF_W-1:0];
  assign m_hi = HALF_W'(m_r[DVD_W-1:HALF_W]);

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (step_r)
      D_MUL1: begin
        mul_a = n_lo;
        mul_b = m_hi;
      end
      D_MUL2: begin
        mul_a = n_hi;
        mul_b = m_lo;
      end
      D_MUL3: begin
        mul_a = n_hi;
        mul_b = m_hi;
      end
      D_FIX: begin
        mul_a = acc_r[DVD_W +: HALF_W];
        mul_b = HALF_W'(d_r);
      end
      default: begin
        mul_a = n_lo;
        mul_b = m_lo;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    step_nxt = step_r;
    done_nxt = 1'b0;
    n_nxt    = n_r;
    m_nxt    = m_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    unique case (step_r)
      D_IDLE: begin
        if (start) begin
          n_nxt    = dividend;
          m_nxt    = recip;
          d_nxt    = divisor;
          acc_nxt  = '0;
          step_nxt = D_MUL0;
        end
      end
      D_MUL0: begin
        acc_nxt  = acc_r + ACC_W'(prod);
        step_nxt = D_MUL1;
      end
      D_MUL1: begin
        acc_nxt  = acc_r + (ACC_W'(prod) << HALF_W);
        step_nxt = D_MUL2;
      end
      D_MUL2: begin
        acc_nxt  = acc_r + (ACC_W'(prod) << HALF_W);
        step_nxt = D_MUL3;
      end
      D_MUL3: begin
        acc_nxt  = acc_r + (ACC_W'(prod) << (2 * HALF_W));
        step_nxt = D_FIX;
      end
      D_FIX: begin
        quo_nxt  = acc_r[ACC_W-1:DVD_W];
        rem_nxt  = n_r[DVS_W:0] - prod[DVS_W:0];
        step_nxt = D_INC;
      end
      D_INC: begin
        if (rem_r >= {1'b0, d_r}) begin
          quo_nxt = quo_r + DVD_W'(1);
        end
        done_nxt = 1'b1;
        step_nxt = D_IDLE;
      end
      default: begin
        step_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    m_r   <= m_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = (step_r != D_IDLE);
  assign rsp.done = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/complex_viewport_pan_zoom_core.sv
// Top level: viewport window registers, command sequencer and output register.
// Divisions by a constant per command: a pan one, a zoom in two (one per axis), a zoom
// out four, the unused mode none. Each division steps through start, four partial
// products and one correction product on the shared multiplier, done.
// Throughput: one command at a time; the next is taken once the result is in the
// output register, even if that result has not been transferred yet.
// Reset (rst_n low, synchronous) sets both axes to minimum -2.0 and span 4.0.
module complex_viewport_pan_zoom_core
  import cvpz_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] axis_imag, [2:1] direction, [12:3] cursor_x, [22:13] cursor_y, [23] zero
  input  logic [23:0]  in_tdata,
  // [1:0] mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] real_low, [62:32] real_span, [94:63] imag_low, [125:95] imag_span,
  // [127:126] zero
  output logic [127:0] out_tdata
);

  // The divisor must hold four times the larger image size.
  localparam int MAX_SIZE = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int DVS_W    = $clog2(ZIN_SCALE * MAX_SIZE + 1);

  localparam logic [DVS_W-1:0] DVS_PAN    = DVS_W'(PAN_DIVISOR);
  localparam logic [DVS_W-1:0] DVS_THIRD  = DVS_W'(ZOUT_SCALE);
  localparam logic [DVS_W-1:0] DVS_ZIN_X  = DVS_W'(ZIN_SCALE * IMAGE_WIDTH);
  localparam logic [DVS_W-1:0] DVS_ZIN_Y  = DVS_W'(ZIN_SCALE * IMAGE_HEIGHT);
  localparam logic [DVS_W-1:0] DVS_ZOUT_X = DVS_W'(ZOUT_SCALE * IMAGE_WIDTH);
  localparam logic [DVS_W-1:0] DVS_ZOUT_Y = DVS_W'(ZOUT_SCALE * IMAGE_HEIGHT);

  // Matching reciprocals, floor(2^DVD_W / divisor), fixed at elaboration.
  localparam longint RCP_ONE = longint'(1) << DVD_W;
  localparam logic [DVD_W-1:0] RCP_PAN    = DVD_W'(RCP_ONE / PAN_DIVISOR);
  localparam logic [DVD_W-1:0] RCP_THIRD  = DVD_W'(RCP_ONE / ZOUT_SCALE);
  localparam logic [DVD_W-1:0] RCP_ZIN_X  = DVD_W'(RCP_ONE / (ZIN_SCALE * IMAGE_WIDTH));
  localparam logic [DVD_W-1:0] RCP_ZIN_Y  = DVD_W'(RCP_ONE / (ZIN_SCALE * IMAGE_HEIGHT));
  localparam logic [DVD_W-1:0] RCP_ZOUT_X = DVD_W'(RCP_ONE / (ZOUT_SCALE * IMAGE_WIDTH));
  localparam logic [DVD_W-1:0] RCP_ZOUT_Y = DVD_W'(RCP_ONE / (ZOUT_SCALE * IMAGE_HEIGHT));

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [LOW_W-1:0] sat_low(input logic signed [WIDE_W-1:0] v);
    logic [LOW_W-1:0] r;
    if (v > LOW_MAX_W) begin
      r = LOW_MAX_W[LOW_W-1:0];
    end else if (v < LOW_MIN_W) begin
      r = LOW_MIN_W[LOW_W-1:0];
    end else begin
      r = v[LOW_W-1:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  // Window state.
  logic [LOW_W-1:0]  rlow_r, ilow_r;
  logic [SPAN_W-1:0] rspan_r, ispan_r;

  // Latched command.
  mode_t             mode_r;
  logic [DIR_W-1:0]  dir_r;
  logic [CUR_W-1:0]  cx_r, cy_r;
  logic              axis_sel_r, axis_sel_nxt;

  // Product of cursor and span, registered ahead of the divider.
  logic [DVD_W-1:0]  prod_r;
  logic [DVD_W-1:0]  prod_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [127:0]      out_data_r;

  // Divider connection.
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_rcp;
  div_rsp_t          div_rsp;
  logic [DVD_W-1:0]  div_quo;

  // Operands of the axis being worked on.
  logic [LOW_W-1:0]  low_cur;
  logic [SPAN_W-1:0] span_cur;
  logic [CUR_W-1:0]  cur_c;

  logic signed [WIDE_W-1:0] low_w, quo_w, span_w, low_t;
  logic [SPAN_W+1:0]        span3;
  logic [LOW_W-1:0]         low_new;
  logic [SPAN_W-1:0]        span_zin;
  logic [SPAN_W-1:0]        span_zout;
  logic                     wr_low, wr_span;
  logic [SPAN_W-1:0]        span_new;
  logic                     in_xfer;
  logic                     last_axis;

  cvpz_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .recip    (div_rcp),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign low_cur  = axis_sel_r ? ilow_r  : rlow_r;
  assign span_cur = axis_sel_r ? ispan_r : rspan_r;
  assign cur_c    = axis_sel_r ? cy_r    : cx_r;

  assign prod_nxt = cur_c * span_cur;

  // A pan touches one axis; zooms finish after the imaginary axis.
  assign last_axis = (mode_r == MODE_PAN) || axis_sel_r;

  // Divider operands: the low-edge term in the first division of an axis, the
  // four-thirds span growth in the second division of a zoom out.
  always_comb begin
    div_start = (state_r == S_STL) || (state_r == S_STS);
    div_dvd   = prod_r;
    div_dvs   = DVS_PAN;
    div_rcp   = RCP_PAN;
    if (state_r == S_STS) begin
      div_dvd = DVD_W'({span_cur, 2'b00});
      div_dvs = DVS_THIRD;
      div_rcp = RCP_THIRD;
    end else begin
      case (mode_r)
        MODE_ZIN: begin
          div_dvd = prod_r;
          div_dvs = axis_sel_r ? DVS_ZIN_Y : DVS_ZIN_X;
          div_rcp = axis_sel_r ? RCP_ZIN_Y : RCP_ZIN_X;
        end
        MODE_ZOUT: begin
          div_dvd = prod_r;
          div_dvs = axis_sel_r ? DVS_ZOUT_Y : DVS_ZOUT_X;
          div_rcp = axis_sel_r ? RCP_ZOUT_Y : RCP_ZOUT_X;
        end
        default: begin
          div_dvd = DVD_W'(span_cur);
          div_dvs = DVS_PAN;
          div_rcp = RCP_PAN;
        end
      endcase
    end
  end

  // Low-edge update from the first quotient of the axis.
  assign low_w = WIDE_W'(signed'(low_cur));
  assign quo_w = signed'(WIDE_W'(div_quo));
  assign span_w = signed'(WIDE_W'(span_cur));

  always_comb begin
    low_t = low_w;
    case (mode_r)
      MODE_PAN: begin
        if (dir_r == DIR_UP) begin
          low_t = low_w + quo_w;
          if (low_t + span_w > POS_TWO_W) begin
            low_t = POS_TWO_W - span_w;
          end
        end else if (dir_r[1]) begin
          low_t = low_w - quo_w;
          if (low_t < NEG_TWO_W) begin
            low_t = NEG_TWO_W;
          end
        end
      end
      MODE_ZIN: begin
        low_t = low_w + quo_w;
      end
      MODE_ZOUT: begin
        low_t = low_w - quo_w;
        if (low_t < NEG_TWO_W) begin
          low_t = NEG_TWO_W;
        end
      end
      default: begin
        low_t = low_w;
      end
    endcase
  end

  assign low_new = sat_low(low_t);

  // Zoom in: three quarters of the span, floored.
  assign span3    = (SPAN_W+2)'(span_cur) + (SPAN_W+2)'({span_cur, 1'b0});
  assign span_zin = span3[SPAN_W+1:2];

  // Zoom out: quotient of four times the span by three, capped at 4.0.
  assign span_zout = (div_quo > DVD_W'(SPAN_MAX)) ? SPAN_MAX : div_quo[SPAN_W-1:0];

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    axis_sel_nxt  = axis_sel_r;
    wr_low        = 1'b0;
    wr_span       = 1'b0;
    span_new      = span_zin;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          axis_sel_nxt = (mode_t'(in_tuser) == MODE_PAN) ? in_tdata[0] : 1'b0;
          state_nxt    = (mode_t'(in_tuser) == MODE_NONE) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_STL;
      end
      S_STL: begin
        state_nxt = S_WTL;
      end
      S_WTL: begin
        if (div_rsp.done) begin
          wr_low = 1'b1;
          if (mode_r == MODE_ZIN) begin
            wr_span  = 1'b1;
            span_new = span_zin;
          end
          if (mode_r == MODE_ZOUT) begin
            state_nxt = S_STS;
          end else if (last_axis) begin
            state_nxt = S_DONE;
          end else begin
            axis_sel_nxt = 1'b1;
            state_nxt    = S_MUL;
          end
        end
      end
      S_STS: begin
        state_nxt = S_WTS;
      end
      S_WTS: begin
        if (div_rsp.done) begin
          wr_span  = 1'b1;
          span_new = span_zout;
          if (last_axis) begin
            state_nxt = S_DONE;
          end else begin
            axis_sel_nxt = 1'b1;
            state_nxt    = S_MUL;
          end
        end
      end
      S_DONE: begin
        // The result waits here only while an earlier one is still unread.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_sel_r  <= 1'b0;
      rlow_r      <= LOW_RST;
      ilow_r      <= LOW_RST;
      rspan_r     <= SPAN_RST;
      ispan_r     <= SPAN_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      axis_sel_r  <= axis_sel_nxt;
      if (wr_low) begin
        if (axis_sel_r) begin
          ilow_r <= low_new;
        end else begin
          rlow_r <= low_new;
        end
      end
      if (wr_span) begin
        if (axis_sel_r) begin
          ispan_r <= span_new;
        end else begin
          rspan_r <= span_new;
        end
      end
    end
  end

  // Command fields and datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= mode_t'(in_tuser);
      dir_r  <= in_tdata[2:1];
      cx_r   <= in_tdata[12:3];
      cy_r   <= in_tdata[22:13];
    end
    if (state_r == S_MUL) begin
      prod_r <= prod_nxt;
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
      out_data_r <= {2'b00, ispan_r, ilow_r, rspan_r, rlow_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/cvpz_chk.sv
// Port-level checker for the viewport core, bound to the top level.
module cvpz_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // No result is shown in the cycle after a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A held result keeps its data until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The core works on one command at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in progress");

  // Both spans stay at or below 4.0.
  a_span_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[62:32] <= 31'h4000_0000) &&
                   (out_tdata[125:95] <= 31'h4000_0000))
    else $error("span above 4.0");

  // Both minimums stay at or above -2.0.
  a_low_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) >= -32'sd536870912) &&
                   ($signed(out_tdata[94:63]) >= -32'sd536870912))
    else $error("minimum below -2.0");

endmodule

bind complex_viewport_pan_zoom_core cvpz_chk u_cvpz_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/complex_viewport_pan_zoom_core_test.sv
// Self-checking testbench for the complex viewport pan and zoom core.
module complex_viewport_pan_zoom_core_test;
  import cvpz_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Image geometry used by the zoom commands; matches the DUT parameters.
  localparam int IMG_W = 1024;
  localparam int IMG_H = 1024;

  // Q3.28 landmarks of the viewport arithmetic, held at 64 bits so that
  // every intermediate sum and product is exact.
  localparam longint Q_NEG_TWO = -64'sd536870912;
  localparam longint Q_POS_TWO = 64'sd536870912;
  localparam longint Q_FOUR    = 64'sd1073741824;
  localparam longint Q_LOW_MAX = 64'sd2147483647;
  localparam longint Q_LOW_MIN = -64'sd2147483648;

  // Pan direction codes. Both negative encodings move toward lower values.
  localparam logic [DIR_W-1:0] DIR_HOLD     = 2'b00;
  localparam logic [DIR_W-1:0] DIR_DOWN     = 2'b11;
  localparam logic [DIR_W-1:0] DIR_DOWN_ALT = 2'b10;

  // Number of random commands to issue after the directed opening.
  localparam int RANDOM_CMDS = 1430;

  // Cycles to let pass once every expected window has arrived; covers the
  // slowest command (zoom out) with margin.
  localparam int DRAIN_CYCLES = 250;

  // One viewport command as it is carried by an input transfer.
  typedef struct {
    mode_t            mode;
    logic             axis;
    logic [DIR_W-1:0] dir;
    logic [CUR_W-1:0] cx;
    logic [CUR_W-1:0] cy;
  } view_cmd_t;

  // One reported window as it is carried by an output transfer.
  typedef struct {
    logic [LOW_W-1:0]  real_low;
    logic [SPAN_W-1:0] real_span;
    logic [LOW_W-1:0]  imag_low;
    logic [SPAN_W-1:0] imag_span;
  } window_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // [0] axis_imag, [2:1] direction, [12:3] cursor_x, [22:13] cursor_y, [23] zero
  logic [23:0]  in_tdata = '0;
  // [1:0] mode
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] real_low, [62:32] real_span, [94:63] imag_low, [125:95] imag_span,
  // [127:126] zero
  logic [127:0] out_tdata;

  // Commands waiting to be offered, and windows still owed by the DUT.
  view_cmd_t cmd_q[$];
  window_t   window_q[$];

  // The testbench's own copy of the viewport.
  longint view_real_low;
  longint view_real_span;
  longint view_imag_low;
  longint view_imag_span;

  int  fail_cnt = 0;
  // When set, neither side inserts gaps; the stimulus sets it afresh for each burst.
  bit  no_gaps = 1'b0;

  complex_viewport_pan_zoom_core #(
    .IMAGE_WIDTH  (IMG_W),
    .IMAGE_HEIGHT (IMG_H)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Viewport predictor.
  // ------------------------------------------------------------------------

  // A minimum edge saturates at the limits of a signed 32-bit word.
  function automatic longint sat_low(input longint v);
    if (v > Q_LOW_MAX) return Q_LOW_MAX;
    if (v < Q_LOW_MIN) return Q_LOW_MIN;
    return v;
  endfunction

  // Pan moves the minimum by a tenth of the span, unless the code is hold, and then
  // keeps the window inside -2..2 on that axis.
  task automatic pan_axis(inout longint low, input longint span,
                          input logic [DIR_W-1:0] dir);
    longint step;
    step = span / 10;
    if (dir == DIR_UP) begin
      low = low + step;
      if (low + span > Q_POS_TWO) low = Q_POS_TWO - span;
    end else if (dir != DIR_HOLD) begin
      low = low - step;
      if (low < Q_NEG_TWO) low = Q_NEG_TWO;
    end
    low = sat_low(low);
  endtask

  // Zoom in keeps the point under the cursor fixed while the span drops to
  // three quarters.
  task automatic zoom_in_axis(inout longint low, inout longint span,
                              input longint cur, input longint size);
    low  = sat_low(low + (cur * span) / (4 * size));
    span = (span * 3) / 4;
  endtask

  // Zoom out grows the span by four thirds about the cursor; the minimum is
  // held at -2 and the span at 4.
  task automatic zoom_out_axis(inout longint low, inout longint span,
                               input longint cur, input longint size);
    low = low - (cur * span) / (3 * size);
    if (low < Q_NEG_TWO) low = Q_NEG_TWO;
    low  = sat_low(low);
    span = (span * 4) / 3;
    if (span > Q_FOUR) span = Q_FOUR;
  endtask

  // Applies one accepted command and queues the window the DUT must report.
  task automatic apply_view_cmd(input view_cmd_t c);
    window_t w;
    case (c.mode)
      MODE_PAN: begin
        if (c.axis) pan_axis(view_imag_low, view_imag_span, c.dir);
        else        pan_axis(view_real_low, view_real_span, c.dir);
      end
      MODE_ZIN: begin
        zoom_in_axis(view_real_low, view_real_span, longint'(c.cx), IMG_W);
        zoom_in_axis(view_imag_low, view_imag_span, longint'(c.cy), IMG_H);
      end
      MODE_ZOUT: begin
        zoom_out_axis(view_real_low, view_real_span, longint'(c.cx), IMG_W);
        zoom_out_axis(view_imag_low, view_imag_span, longint'(c.cy), IMG_H);
      end
      default: begin
        // The unused mode leaves the window untouched but still reports it.
      end
    endcase
    w.real_low  = view_real_low[LOW_W-1:0];
    w.real_span = view_real_span[SPAN_W-1:0];
    w.imag_low  = view_imag_low[LOW_W-1:0];
    w.imag_span = view_imag_span[SPAN_W-1:0];
    window_q.push_back(w);
  endtask

  // ------------------------------------------------------------------------
  // Gaps on both sides: none in half of the draws, mostly short otherwise, now and
  // then long enough to straddle a whole zoom-out computation.
  // ------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 80) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 60);
    return $urandom_range(61, 120);
  endfunction

  // ------------------------------------------------------------------------
  // Driver. The command at the head of cmd_q is offered until its transfer
  // completes; only then is it removed and handed to the predictor, so the
  // expectation is in place before the DUT can possibly answer.
  // ------------------------------------------------------------------------
  int drv_idle = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      drv_idle  = 0;
    end else if (in_tvalid && !in_tready) begin
      // Hold the offer steady until the DUT takes it.
    end else begin
      if (in_tvalid) begin
        apply_view_cmd(cmd_q.pop_front());
        drv_idle = pick_gap();
      end
      if (drv_idle > 0) begin
        drv_idle--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= cmd_q[0].mode;
        in_tdata  <= {1'b0, cmd_q[0].cy, cmd_q[0].cx, cmd_q[0].dir, cmd_q[0].axis};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor. Every output transfer is checked field by field against the
  // oldest predicted window; out_tready stalls at random.
  // ------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [LOW_W-1:0] exp_v,
                             input logic [LOW_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  int mon_stall = 0;

  always @(posedge clk) begin
    window_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mon_stall  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (window_q.size() == 0) begin
          $error("window transfer with no command outstanding: %h", out_tdata);
          fail_cnt++;
        end else begin
          w = window_q.pop_front();
          check_field("real_low",  w.real_low,            out_tdata[31:0]);
          check_field("real_span", {1'b0, w.real_span},   {1'b0, out_tdata[62:32]});
          check_field("imag_low",  w.imag_low,            out_tdata[94:63]);
          check_field("imag_span", {1'b0, w.imag_span},   {1'b0, out_tdata[125:95]});
        end
        mon_stall = pick_gap();
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus.
  // ------------------------------------------------------------------------
  function automatic view_cmd_t make_cmd(input mode_t m);
    view_cmd_t c;
    c.mode = m;
    c.axis = 1'($urandom_range(0, 1));
    c.dir  = DIR_W'($urandom_range(0, 3));
    c.cx   = CUR_W'($urandom_range(0, 1023));
    c.cy   = CUR_W'($urandom_range(0, 1023));
    return c;
  endfunction

  task automatic push_cmd(input mode_t m, input logic axis, input logic [DIR_W-1:0] dir,
                          input int cx, input int cy);
    view_cmd_t c;
    c.mode = m;
    c.axis = axis;
    c.dir  = dir;
    c.cx   = CUR_W'(cx);
    c.cy   = CUR_W'(cy);
    cmd_q.push_back(c);
  endtask

  function automatic mode_t pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return MODE_PAN;
    if (roll < 68) return MODE_ZIN;
    if (roll < 94) return MODE_ZOUT;
    return MODE_NONE;
  endfunction

  // Waits until the driver has offered and completed everything queued.
  task automatic wait_cmds_sent();
    while (cmd_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int issued;
    int burst;
    int len;
    view_cmd_t c;

    view_real_low  = Q_NEG_TWO;
    view_real_span = Q_FOUR;
    view_imag_low  = Q_NEG_TWO;
    view_imag_span = Q_FOUR;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. On the full window every moving pan is clamped at once.
    push_cmd(MODE_PAN,  1'b0, DIR_DOWN,     0,    0);
    push_cmd(MODE_PAN,  1'b1, DIR_UP,       1023, 1023);
    push_cmd(MODE_PAN,  1'b0, DIR_HOLD,     512,  512);
    // A zoom-out of the full window clamps both the minimum and the span.
    push_cmd(MODE_ZOUT, 1'b0, DIR_HOLD,     1023, 1023);
    // Zoom in at both corners and off-center, then pan inside the window.
    push_cmd(MODE_ZIN,  1'b0, DIR_HOLD,     0,    0);
    push_cmd(MODE_ZIN,  1'b1, DIR_UP,       1023, 1023);
    push_cmd(MODE_ZIN,  1'b0, DIR_DOWN,     512,  0);
    push_cmd(MODE_PAN,  1'b0, DIR_UP,       0,    1023);
    push_cmd(MODE_PAN,  1'b1, DIR_DOWN,     1023, 0);
    // The alternate negative direction code also pans toward lower values.
    push_cmd(MODE_PAN,  1'b0, DIR_DOWN_ALT, 341,  682);
    push_cmd(MODE_PAN,  1'b1, DIR_DOWN_ALT, 682,  341);
    // The unused mode reports the window unchanged, whatever its fields.
    push_cmd(MODE_NONE, 1'b1, DIR_UP,       1023, 1023);
    push_cmd(MODE_NONE, 1'b0, DIR_HOLD,     0,    0);
    // Pan up on the imaginary axis repeatedly, toward the upper edge at 2.0.
    for (int i = 0; i < 6; i++) push_cmd(MODE_PAN, 1'b1, DIR_UP, 0, 0);
    // Zoom out at the far corner back to the full window.
    for (int i = 0; i < 4; i++) push_cmd(MODE_ZOUT, 1'b0, DIR_HOLD, 1023, 1023);
    push_cmd(MODE_ZOUT, 1'b1, DIR_DOWN,     0,    0);
    wait_cmds_sent();

    // Random bursts of various shapes. Deep zoom-in dives shrink the window
    // far enough that pans and zoom-outs exercise the clamps from inside.
    issued = 0;
    while (issued < RANDOM_CMDS) begin
      burst   = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 4) == 0);
      case (burst)
        0, 1, 2: begin
          len = $urandom_range(10, 40);
          for (int i = 0; i < len; i++) cmd_q.push_back(make_cmd(pick_mode()));
        end
        3, 4: begin
          // Dive: mostly zoom-in with a few pans mixed in.
          len = $urandom_range(5, 30);
          for (int i = 0; i < len; i++)
            cmd_q.push_back(make_cmd(($urandom_range(0, 4) == 0) ? MODE_PAN : MODE_ZIN));
        end
        5, 6: begin
          // Climb back out toward the full window.
          len = $urandom_range(3, 15);
          for (int i = 0; i < len; i++) cmd_q.push_back(make_cmd(MODE_ZOUT));
        end
        7, 8: begin
          // Sweep one axis, mostly in one direction, toward its edge.
          len = $urandom_range(5, 30);
          c   = make_cmd(MODE_PAN);
          for (int i = 0; i < len; i++) begin
            c.cx = CUR_W'($urandom_range(0, 1023));
            c.cy = CUR_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 9) == 0) c.dir = DIR_W'($urandom_range(0, 3));
            cmd_q.push_back(c);
          end
        end
        default: begin
          // Noise: unused mode and pans that do not move.
          len = $urandom_range(2, 6);
          for (int i = 0; i < len; i++) begin
            c = make_cmd(MODE_NONE);
            if ($urandom_range(0, 1) == 0) begin
              c.mode = MODE_PAN;
              c.dir  = DIR_HOLD;
            end
            cmd_q.push_back(c);
          end
        end
      endcase
      issued += len;
      wait_cmds_sent();
    end

    // Let every owed window arrive, then give the DUT time to show any
    // stray extra transfer.
    while (window_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("[complex_viewport_pan_zoom_core] OK");
    end else begin
      $display("[complex_viewport_pan_zoom_core] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of the whole stimulus.
  initial begin
    #20_000_000;
    $display("[complex_viewport_pan_zoom_core] ERROR");
    $finish;
  end

endmodule
